@@ design/scc_pkg.sv @@
// Shared types and constants of the sector cache clock replacement unit.
package scc_pkg;

  localparam int unsigned SECTOR_W    = 32;
  localparam int unsigned IDX_OUT_W   = 6;
  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned MAX_RESULTS = 64;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0]          command;
    logic [SECTOR_W-1:0] sector;
  } in_word_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] entry_index;
    logic                 hit;
    logic                 fill_request;
    logic                 writeback_request;
    logic [SECTOR_W-1:0]  writeback_sector;
    logic                 last;
  } out_word_t;

endpackage

@@ design/scc_tag_ram.sv @@
// Tag store: one write port, one read port with registered read data.
module scc_tag_ram #(
  parameter int unsigned DEPTH = scc_pkg::ENTRIES_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int unsigned DW    = scc_pkg::SECTOR_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/sector_cache_clock_replacement_unit.sv @@
// Top level of the sector cache tag and clock replacement controller.
//
// Usage: the input channel (in_valid, in_stall, in_data) takes one word per
// command: read access, write access or flush. The result channel (out_valid,
// out_stall, out_data) returns one word per access and, for a flush, one word
// per dirty entry written back (or a single empty word), the final one marked
// by last. Command code 3 is taken and dropped without any result.
// Flow: in_stall is high from acceptance until the last result of the word
// has been handed to the output register. An access scans the tag RAM one
// entry per cycle through its single read port and stops at a hit; a miss
// then walks the clock hand one entry per cycle, installs the sector and
// loads the result once the output register is free. The next word is taken
// once the block is back in idle. A flush loads its final word when its scan
// ends or MAX_RESULTS writebacks have been found.
// Reset clears the valid, dirty and reference bits and the clock hand; the
// tag RAM is not cleared, since entries are only compared once valid.
// When the receiver stalls, the result holds in the output register; a new
// command is still taken once the block is idle, and a flush pauses its scan.
module sector_cache_clock_replacement_unit #(
  parameter int unsigned ENTRIES = scc_pkg::ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  scc_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output scc_pkg::out_word_t out_data
);
  import scc_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = IW + 1;
  localparam int unsigned KW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOOKUP = 6'b000010,
    ST_FLUSH  = 6'b000100,
    ST_SWEEP  = 6'b001000,
    ST_VFIN   = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic                is_write_r, is_write_nxt;
  logic [SECTOR_W-1:0] sec_r, sec_nxt;
  logic [CW-1:0]       scan_idx_r, scan_idx_nxt;
  logic [IW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]       cur_r, cur_nxt;
  logic [IW-1:0]       sweep_ptr_r, sweep_ptr_nxt;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [ENTRIES-1:0]  dirty_r, dirty_nxt;
  logic [ENTRIES-1:0]  ref_r, ref_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  out_word_t           pend_r, pend_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_data_r, out_data_nxt;

  logic                in_acc;
  logic                out_free;
  logic                scan_done;
  logic                cmp_hit;
  logic                cmp_dirty;
  logic                flush_hold;
  logic                vic_wb;
  logic [IW-1:0]       cur_inc;

  logic                ram_we;
  logic [IW-1:0]       ram_raddr;
  logic [SECTOR_W-1:0] ram_q;

  scc_tag_ram #(
    .DEPTH (ENTRIES),
    .AW    (IW),
    .DW    (SECTOR_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_r),
    .wdata (sec_r),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_done = !cmp_vld_r && (scan_idx_r == CW'(ENTRIES));
  // ram_q holds the tag of cmp_idx_r: it was read in the cycle that issued it
  assign cmp_hit   = cmp_vld_r && valid_r[cmp_idx_r] && (ram_q == sec_r);
  assign cmp_dirty = cmp_vld_r && valid_r[cmp_idx_r] && dirty_r[cmp_idx_r] &&
                     (k_r < KW'(MAX_RESULTS));
  // a second writeback found while the previous one cannot leave: freeze scan
  assign flush_hold = cmp_dirty && pend_vld_r && !out_free;
  assign vic_wb     = valid_r[cur_r] && dirty_r[cur_r];
  assign cur_inc    = (cur_r == IW'(ENTRIES - 1)) ? '0 : cur_r + IW'(1);

  always_comb begin
    state_nxt     = state_r;
    is_write_nxt  = is_write_r;
    sec_nxt       = sec_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    cur_nxt       = cur_r;
    sweep_ptr_nxt = sweep_ptr_r;
    valid_nxt     = valid_r;
    dirty_nxt     = dirty_r;
    ref_nxt       = ref_r;
    k_nxt         = k_r;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_raddr     = '0;

    // advance the tag scan by one entry (lookup and flush share it)
    if ((state_r == ST_LOOKUP) || ((state_r == ST_FLUSH) && !flush_hold)) begin
      if (scan_idx_r != CW'(ENTRIES)) begin
        ram_raddr    = scan_idx_r[IW-1:0];
        cmp_idx_nxt  = scan_idx_r[IW-1:0];
        cmp_vld_nxt  = 1'b1;
        scan_idx_nxt = scan_idx_r + CW'(1);
      end else begin
        cmp_vld_nxt = 1'b0;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sec_nxt      = in_data.sector;
          is_write_nxt = (in_data.command == CMD_WRITE);
          scan_idx_nxt = '0;
          cmp_vld_nxt  = 1'b0;
          k_nxt        = '0;
          pend_vld_nxt = 1'b0;
          priority if ((in_data.command == CMD_READ) ||
                       (in_data.command == CMD_WRITE)) begin
            state_nxt = ST_LOOKUP;
          end else if (in_data.command == CMD_FLUSH) begin
            state_nxt = ST_FLUSH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_LOOKUP: begin
        if (cmp_hit) begin
          ref_nxt[cmp_idx_r] = 1'b0;
          if (is_write_r) begin
            dirty_nxt[cmp_idx_r] = 1'b1;
          end
          pend_nxt = '{entry_index: IDX_OUT_W'(cmp_idx_r), hit: 1'b1,
                       fill_request: 1'b0, writeback_request: 1'b0,
                       writeback_sector: '0, last: 1'b1};
          state_nxt = ST_RESULT;
        end else if (scan_done) begin
          cur_nxt   = sweep_ptr_r;
          state_nxt = ST_SWEEP;
        end
      end

      ST_SWEEP: begin
        // read the tag under the hand so it is ready if this is the victim
        ram_raddr = cur_r;
        if (!valid_r[cur_r] || ref_r[cur_r]) begin
          sweep_ptr_nxt = cur_inc;
          state_nxt     = ST_VFIN;
        end else begin
          ref_nxt[cur_r] = 1'b1;
          cur_nxt        = cur_inc;
        end
      end

      ST_VFIN: begin
        pend_nxt = '{entry_index: IDX_OUT_W'(cur_r), hit: 1'b0,
                     fill_request: 1'b1, writeback_request: vic_wb,
                     writeback_sector: vic_wb ? ram_q : '0, last: 1'b1};
        ram_we           = 1'b1;
        valid_nxt[cur_r] = 1'b1;
        dirty_nxt[cur_r] = is_write_r;
        ref_nxt[cur_r]   = 1'b0;
        state_nxt        = ST_RESULT;
      end

      ST_FLUSH: begin
        if (flush_hold) begin
          // keep the read data of the held entry
          ram_raddr = cmp_idx_r;
        end else if (cmp_dirty) begin
          dirty_nxt[cmp_idx_r] = 1'b0;
          k_nxt                = k_r + KW'(1);
          if (pend_vld_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = pend_r;
          end
          pend_nxt = '{entry_index: IDX_OUT_W'(cmp_idx_r), hit: 1'b0,
                       fill_request: 1'b0, writeback_request: 1'b1,
                       writeback_sector: ram_q, last: 1'b0};
          pend_vld_nxt = 1'b1;
        end else if (scan_done || (k_r == KW'(MAX_RESULTS))) begin
          if (pend_vld_r) begin
            pend_nxt.last = 1'b1;
          end else begin
            pend_nxt = '{entry_index: '0, hit: 1'b0, fill_request: 1'b0,
                         writeback_request: 1'b0, writeback_sector: '0,
                         last: 1'b1};
          end
          state_nxt = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pend_r;
          pend_vld_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_vld_r   <= 1'b0;
      sweep_ptr_r <= '0;
      valid_r     <= '0;
      dirty_r     <= '0;
      ref_r       <= '0;
      k_r         <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      sweep_ptr_r <= sweep_ptr_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      ref_r       <= ref_nxt;
      k_r         <= k_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_write_r <= is_write_nxt;
    sec_r      <= sec_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    cur_r      <= cur_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the victim chosen by the hand is free or already passed over once
  a_victim_eligible: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VFIN) |-> (!valid_r[cur_r] || ref_r[cur_r]))
    else $error("victim entry is valid with clear reference bit");

  // an installed entry is valid and unreferenced afterwards
  a_install_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VFIN) |=> (valid_r[$past(cur_r)] && !ref_r[$past(cur_r)]))
    else $error("installed entry not valid");

  // the clock hand stays inside the table
  a_hand_range: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_ptr_r <= IW'(ENTRIES - 1))
    else $error("sweep pointer out of range");

  // a hit never asks for disk traffic
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.hit) |->
      (!out_data_r.fill_request && !out_data_r.writeback_request && out_data_r.last))
    else $error("hit result requests disk traffic");

  // a flush only holds its scan while a writeback waits to leave
  a_flush_pend: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FLUSH) && pend_vld_r) |-> pend_r.writeback_request)
    else $error("flush pending word is not a writeback");

endmodule
